>>> rtl/core/clre_pkg.sv
`timescale 1ns / 1ps
// Package for the console line receiver: character codes, result kinds
// and field widths. No dependencies.
package clre_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [LEN_W-1:0]  len_t;

    localparam byte_t CH_BS            = 8'h08;
    localparam byte_t CH_LF            = 8'h0A;
    localparam byte_t CH_CR            = 8'h0D;
    localparam byte_t CH_FIRST_PRINT   = 8'h20;
    localparam byte_t CH_LAST_PRINT    = 8'h7E;

    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    localparam kind_t KIND_ECHO       = 2'd0;
    localparam kind_t KIND_LINE_BYTE  = 2'd1;
    localparam kind_t KIND_EMPTY_LINE = 2'd2;

endpackage

>>> rtl/core/clre_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module clre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/console_line_receiver_with_echo.sv
`timescale 1ns / 1ps
// Console line receiver with echo: line editing, echo and line delivery.
// Depends on clre_pkg and clre_ram.
// Received byte: a backspace echo appears in the next cycle.
// Poll tick: one result per cycle while m_tready does not stall, read from
// the line store's registered port; no input is taken during a run.
// Reset (aresetn low at a clock edge) clears the count, echo position and
// flags; the line store holds unspecified data until written.
module console_line_receiver_with_echo #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data, [13:8] line_length, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam int CW = $clog2(LINE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef logic [CW-1:0] cnt_t;

    logic state_reg, state_next;
    cnt_t count_reg, count_next;
    cnt_t echo_reg, echo_next;
    logic cr_reg, cr_next;
    logic done_reg, done_next;
    cnt_t ptr_reg, ptr_next;
    cnt_t end_reg, end_next;
    logic deliver_reg, deliver_next;

    logic            m_valid_reg, m_valid_next;
    clre_pkg::kind_t m_kind_reg, m_kind_next;
    logic            m_last_reg, m_last_next;
    clre_pkg::len_t  m_len_reg, m_len_next;
    logic            m_ram_reg, m_ram_next;
    clre_pkg::byte_t m_const_reg, m_const_next;

    logic            advance;
    logic            s_xfer;
    logic            ram_we;
    logic            ram_re;
    clre_pkg::byte_t ram_rdata;
    clre_pkg::byte_t rx;
    cnt_t            count_dec;
    cnt_t            count_inc;
    logic            printable;

    clre_ram #(
        .WIDTH (clre_pkg::BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg),
        .wdata (rx),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign rx        = s_tdata;
    assign count_dec = count_reg - cnt_t'(1);
    assign count_inc = count_reg + cnt_t'(1);
    assign printable = (rx >= clre_pkg::CH_FIRST_PRINT) && (rx <= clre_pkg::CH_LAST_PRINT);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        echo_next    = echo_reg;
        cr_next      = cr_reg;
        done_next    = done_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        deliver_next = deliver_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        m_len_next   = m_len_reg;
        m_ram_next   = m_ram_reg;
        m_const_next = m_const_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (advance) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == clre_pkg::OP_RX_BYTE) begin
                        if (rx == clre_pkg::CH_BS) begin
                            if (!done_reg && count_reg != '0) begin
                                count_next   = count_dec;
                                echo_next    = (echo_reg > count_dec) ? count_dec : echo_reg;
                                m_valid_next = 1'b1;
                                m_kind_next  = clre_pkg::KIND_ECHO;
                                m_last_next  = 1'b1;
                                m_len_next   = '0;
                                m_ram_next   = 1'b0;
                                m_const_next = clre_pkg::CH_BS;
                            end
                        end else if ((rx == clre_pkg::CH_CR || rx == clre_pkg::CH_LF
                                      || printable) && !done_reg) begin
                            if (cr_reg) begin
                                if (rx != clre_pkg::CH_LF) begin
                                    count_next = '0;
                                    echo_next  = '0;
                                    cr_next    = 1'b0;
                                end else begin
                                    done_next = 1'b1;
                                end
                            end else if (rx == clre_pkg::CH_CR) begin
                                cr_next = 1'b1;
                            end else if (rx == clre_pkg::CH_LF) begin
                                done_next = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                if (count_reg == cnt_t'(LINE_DEPTH - 1)) begin
                                    count_next = '0;
                                    echo_next  = '0;
                                end else begin
                                    count_next = count_inc;
                                end
                            end
                        end
                    end else begin
                        if (echo_reg < count_reg) begin
                            state_next   = ST_RUN;
                            ptr_next     = echo_reg;
                            end_next     = count_reg;
                            deliver_next = 1'b0;
                        end else if (done_reg) begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = clre_pkg::KIND_EMPTY_LINE;
                                m_last_next  = 1'b1;
                                m_len_next   = '0;
                                m_ram_next   = 1'b0;
                                m_const_next = '0;
                                echo_next    = '0;
                                cr_next      = 1'b0;
                                done_next    = 1'b0;
                            end else begin
                                state_next   = ST_RUN;
                                ptr_next     = '0;
                                end_next     = count_reg;
                                deliver_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_RUN: begin
                if (advance) begin
                    ram_re       = 1'b1;
                    m_valid_next = 1'b1;
                    m_ram_next   = 1'b1;
                    m_kind_next  = deliver_reg ? clre_pkg::KIND_LINE_BYTE : clre_pkg::KIND_ECHO;
                    m_len_next   = deliver_reg ? clre_pkg::len_t'(end_reg) : '0;
                    m_last_next  = (ptr_reg + cnt_t'(1)) == end_reg;
                    ptr_next     = ptr_reg + cnt_t'(1);
                    if ((ptr_reg + cnt_t'(1)) == end_reg) begin
                        state_next = ST_IDLE;
                        if (deliver_reg) begin
                            count_next = '0;
                            echo_next  = '0;
                            cr_next    = 1'b0;
                            done_next  = 1'b0;
                        end else begin
                            echo_next = end_reg;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            echo_reg    <= '0;
            cr_reg      <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            echo_reg    <= echo_next;
            cr_reg      <= cr_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        deliver_reg <= deliver_next;
        m_kind_reg  <= m_kind_next;
        m_last_reg  <= m_last_next;
        m_len_reg   <= m_len_next;
        m_ram_reg   <= m_ram_next;
        m_const_reg <= m_const_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_len_reg, (m_ram_reg ? ram_rdata : m_const_reg)};

endmodule

>>> verif/console_line_checker.sv
`timescale 1ns / 1ps
// Checker for the console line receiver: watches both stream channels, keeps its
// own line-editing state, predicts each reply and compares it. Depends on clre_pkg.
module console_line_checker #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          replies_pending,
    output int          replies_checked
);

    typedef struct packed {
        clre_pkg::kind_t kind;
        clre_pkg::byte_t data;
        logic            last;
        clre_pkg::len_t  len;
    } reply_t;

    reply_t          replies_due[$];
    clre_pkg::byte_t line_buf [LINE_DEPTH];
    int              line_len;
    int              echoed;
    logic            cr_pending;
    logic            line_done;
    int              fails;
    int              checked;

    task automatic clear_line();
        line_len   = 0;
        echoed     = 0;
        cr_pending = 1'b0;
    endtask

    task automatic queue_reply(clre_pkg::kind_t kind, clre_pkg::byte_t data, logic last,
                               clre_pkg::len_t len);
        reply_t r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        r.len  = len;
        replies_due.push_back(r);
    endtask

    task automatic edit_line(clre_pkg::byte_t b);
        logic usable;
        usable = (b == clre_pkg::CH_CR) || (b == clre_pkg::CH_LF) ||
                 (b >= clre_pkg::CH_FIRST_PRINT && b <= clre_pkg::CH_LAST_PRINT);
        if (b == clre_pkg::CH_BS) begin
            if (!line_done && line_len != 0) begin
                line_len--;
                if (echoed > line_len)
                    echoed = line_len;
                queue_reply(clre_pkg::KIND_ECHO, clre_pkg::CH_BS, 1'b1, '0);
            end
        end else if (usable && !line_done) begin
            if (cr_pending) begin
                if (b == clre_pkg::CH_LF)
                    line_done = 1'b1;
                else
                    clear_line();
            end else if (b == clre_pkg::CH_CR) begin
                cr_pending = 1'b1;
            end else if (b == clre_pkg::CH_LF) begin
                line_done = 1'b1;
            end else begin
                line_buf[line_len] = b;
                line_len++;
                if (line_len > LINE_DEPTH - 1) begin
                    line_len = 0;
                    echoed   = 0;
                end
            end
        end
    endtask

    task automatic service_poll();
        if (echoed < line_len) begin
            while (echoed < line_len) begin
                queue_reply(clre_pkg::KIND_ECHO, line_buf[echoed], echoed + 1 == line_len,
                            '0);
                echoed++;
            end
        end else if (line_done) begin
            if (line_len == 0) begin
                queue_reply(clre_pkg::KIND_EMPTY_LINE, '0, 1'b1, '0);
            end else begin
                for (int i = 0; i < line_len; i++)
                    queue_reply(clre_pkg::KIND_LINE_BYTE, line_buf[i], i + 1 == line_len,
                                clre_pkg::len_t'(line_len));
            end
            clear_line();
            line_done = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        reply_t want;
        logic   bad;
        if (!aresetn) begin
            replies_due.delete();
            clear_line();
            line_done = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked++;
                if (replies_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result kind=%0d data=%02h last=%0b len=%0d",
                             $time, m_tuser, m_tdata[7:0], m_tlast, m_tdata[13:8]);
                end else begin
                    want = replies_due.pop_front();
                    bad  = (m_tuser !== want.kind) || (m_tdata[7:0] !== want.data) ||
                           (m_tlast !== want.last) || (m_tdata[13:8] !== want.len) ||
                           (m_tdata[15:14] !== 2'b00);
                    if (bad) begin
                        fails++;
                        $display({"%0t: mismatch expected kind=%0d data=%02h last=%0b ",
                                  "len=%0d, got kind=%0d data=%02h last=%0b len=%0d pad=%0b"},
                                 $time, want.kind, want.data, want.last, want.len,
                                 m_tuser, m_tdata[7:0], m_tlast, m_tdata[13:8],
                                 m_tdata[15:14]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == clre_pkg::OP_POLL)
                    service_poll();
                else
                    edit_line(s_tdata);
            end
        end
        fail_count      <= fails;
        replies_pending <= replies_due.size();
        replies_checked <= checked;
    end

    initial begin
        fails           = 0;
        checked         = 0;
        fail_count      = 0;
        replies_pending = 0;
        replies_checked = 0;
        clear_line();
        line_done = 1'b0;
    end

endmodule

>>> verif/tb_console_line_receiver_with_echo.sv
`timescale 1ns / 1ps
// Testbench top for the console line receiver: directed and random line traffic
// with random gaps and stalls, verdict from console_line_checker. Depends on clre_pkg.
module tb_console_line_receiver_with_echo;

    localparam int LINE_DEPTH  = 64;
    localparam int ITEM_TARGET = 330;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE      = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = clre_pkg::OP_RX_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   replies_pending;
    int   replies_checked;
    int   items_sent = 0;
    int   polls_sent = 0;
    int   lines_ended = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;

    always #5 aclk = ~aclk;

    console_line_receiver_with_echo #(.LINE_DEPTH(LINE_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    console_line_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .replies_pending (replies_pending),
        .replies_checked (replies_checked)
    );

    always @(posedge aclk) begin
        int r;
        if (quiet) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 24);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic clre_pkg::byte_t any_printable();
        return clre_pkg::byte_t'($urandom_range(clre_pkg::CH_FIRST_PRINT,
                                                clre_pkg::CH_LAST_PRINT));
    endfunction

    task automatic send_item(logic op, clre_pkg::byte_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == clre_pkg::OP_POLL)
            polls_sent++;
    endtask

    task automatic send_byte(clre_pkg::byte_t b);
        send_item(clre_pkg::OP_RX_BYTE, b);
    endtask

    task automatic send_poll();
        send_item(clre_pkg::OP_POLL, clre_pkg::byte_t'($urandom_range(0, 255)));
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
    endtask

    task automatic send_line(int forced_len);
        int len;
        int r;
        if (forced_len >= 0) begin
            len = forced_len;
        end else begin
            r = $urandom_range(0, 19);
            if (r < 14)
                len = $urandom_range(0, 8);
            else if (r < 18)
                len = $urandom_range(9, 40);
            else if (r == 18)
                len = $urandom_range(55, LINE_DEPTH - 2);
            else
                len = $urandom_range(LINE_DEPTH - 1, LINE_DEPTH + 6);
        end
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_poll();
            else if (r < 23)
                send_byte(clre_pkg::CH_BS);
            else if (r < 28)
                send_byte(clre_pkg::byte_t'($urandom_range(0, 255)));
            send_byte(any_printable());
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
            send_byte(clre_pkg::CH_LF);
        end else if (r < 8) begin
            send_byte(clre_pkg::CH_CR);
            send_byte(clre_pkg::CH_LF);
        end else if (r == 8) begin
            send_byte(clre_pkg::CH_CR);
            send_byte(clre_pkg::byte_t'($urandom_range(0, 255)));
        end else begin
            send_byte(clre_pkg::CH_CR);
            send_byte(clre_pkg::CH_BS);
            send_byte(clre_pkg::CH_LF);
        end
        lines_ended++;
        if ($urandom_range(0, 9) == 0)
            send_byte(clre_pkg::byte_t'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 3)) send_poll();
    endtask

    initial begin
        int r;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_poll();
        send_byte(clre_pkg::CH_BS);
        send_byte(8'h41);
        send_byte(clre_pkg::CH_FIRST_PRINT);
        send_byte(clre_pkg::CH_LAST_PRINT);
        send_poll();
        send_byte(clre_pkg::CH_BS);
        send_poll();
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(clre_pkg::CH_CR);
        send_byte(clre_pkg::CH_BS);
        send_byte(clre_pkg::CH_LF);
        send_byte(clre_pkg::CH_BS);
        send_byte(8'h5A);
        send_poll();
        send_byte(clre_pkg::CH_LF);
        send_poll();
        send_byte(8'h71);
        send_byte(clre_pkg::CH_CR);
        send_byte(8'h78);
        send_poll();
        drain_replies();

        send_line(LINE_DEPTH - 1);
        send_line(LINE_DEPTH - 2);
        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 7)
                send_line(-1);
            else
                repeat ($urandom_range(1, 4))
                    send_item(logic'($urandom_range(0, 1)),
                              clre_pkg::byte_t'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0)
                drain_replies();
        end
        quiet = 1'b0;

        drain_replies();
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d items (%0d polls), %0d lines ended by LF, CR LF or a broken CR.",
                 items_sent, polls_sent, lines_ended);
        $display("Checked %0d echo and line results under random gaps and stalls.",
                 replies_checked);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
